>>> sv/quaternion_slerp_unit_defines.svh
// assertion macros shared by the slerp unit
`ifndef QUATERNION_SLERP_UNIT_DEFINES_SVH
`define QUATERNION_SLERP_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle or after a fixed delay
`define QSL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qsl assertion failed");

// consequent holds in the cycle after the antecedent
`define QSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qsl assertion failed");

`endif

>>> sv/qsl_pkg.sv
package qsl_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned IsqrtSteps  = 31;
  localparam int unsigned QuotBits    = 40;
  localparam int unsigned CordicGain  = 652032874;
  localparam int unsigned OneQ28      = 268435456;
  localparam int unsigned EpsQ28      = 2684;
  localparam int unsigned TOne        = 32768;

  localparam logic [30:0] AtanQ30 [CordicSteps] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
    31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
    31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128,       31'd64,
    31'd32,        31'd16,        31'd8,         31'd4,         31'd2
  };

  typedef struct packed {
    logic signed [15:0] first_w;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic        [15:0] fraction;
  } qsl_req_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } qsl_res_t;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [15:0]      t;
    logic             linear;
  } qsl_side_t;

  typedef struct packed {
    qsl_side_t   side;
    logic [29:0] c30;
  } qsl_sq_t;

  typedef struct packed {
    qsl_side_t   side;
    logic [30:0] root;
  } qsl_vec_t;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic             linear;
    logic [30:0]      root;
  } qsl_lane_a_t;

  typedef struct packed {
    logic [3:0][16:0] b;
    logic [15:0]      t;
  } qsl_lane_b_t;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic             linear;
  } qsl_div_a_t;

endpackage

>>> sv/qsl_isqrt.sv
module qsl_isqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [60:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [30:0]      root_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned Steps = qsl_pkg::IsqrtSteps;

  logic [61:0]      v_s    [Steps+1];
  logic [61:0]      res_s  [Steps+1];
  logic [SideW-1:0] side_s [Steps+1];
  logic             vld_s  [Steps+1];

  assign v_s[0]    = {1'b0, rad_i};
  assign res_s[0]  = '0;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [61:0] Bit = 62'(1) << (2 * (Steps - 1 - k));
    logic [61:0] trial;
    logic        ge;
    logic [61:0] v_q, res_q;
    logic [SideW-1:0] side_q;
    logic        vld_q;

    assign trial = res_s[k] + Bit;
    assign ge    = v_s[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      v_q    <= ge ? v_s[k] - trial : v_s[k];
      res_q  <= ge ? (res_s[k] >> 1) + Bit : res_s[k] >> 1;
      side_q <= side_s[k];
    end

    assign v_s[k+1]    = v_q;
    assign res_s[k+1]  = res_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[Steps];
  assign root_o  = res_s[Steps][30:0];
  assign side_o  = side_s[Steps];

endmodule

>>> sv/qsl_cordic.sv
module qsl_cordic #(
  parameter bit          Vectoring = 1'b0,
  parameter int unsigned SideW     = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [33:0] x_i,
  input  logic signed [33:0] y_i,
  input  logic signed [32:0] z_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic signed [33:0] y_o,
  output logic signed [32:0] z_o,
  output logic [SideW-1:0]   side_o
);

  localparam int unsigned Steps = qsl_pkg::CordicSteps;

  logic signed [33:0] x_s    [Steps+1];
  logic signed [33:0] y_s    [Steps+1];
  logic signed [32:0] z_s    [Steps+1];
  logic [SideW-1:0]   side_s [Steps+1];
  logic               vld_s  [Steps+1];

  assign x_s[0]    = x_i;
  assign y_s[0]    = y_i;
  assign z_s[0]    = z_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic signed [32:0] Atan = $signed({2'b00, qsl_pkg::AtanQ30[k]});
    logic signed [33:0] xs, ys;
    logic               up;
    logic signed [33:0] x_q, y_q;
    logic signed [32:0] z_q;
    logic [SideW-1:0]   side_q;
    logic               vld_q;

    assign xs = x_s[k] >>> k;
    assign ys = y_s[k] >>> k;
    // up: y gains x, angle register loses the table entry
    assign up = Vectoring ? (y_s[k] <= 34'sd0) : (z_s[k] >= 33'sd0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q    <= up ? x_s[k] - ys : x_s[k] + ys;
      y_q    <= up ? y_s[k] + xs : y_s[k] - xs;
      z_q    <= up ? z_s[k] - Atan : z_s[k] + Atan;
      side_q <= side_s[k];
    end

    assign x_s[k+1]    = x_q;
    assign y_s[k+1]    = y_q;
    assign z_s[k+1]    = z_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[Steps];
  assign y_o     = y_s[Steps];
  assign z_o     = z_s[Steps];
  assign side_o  = side_s[Steps];

endmodule

>>> sv/qsl_divider.sv
module qsl_divider #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [30:0]      num_i,
  input  logic [30:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [qsl_pkg::QuotBits-1:0] quot_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned Steps = qsl_pkg::QuotBits;

  logic [30:0]      rem_s  [Steps+1];
  logic [Steps-1:0] lo_s   [Steps+1];
  logic [Steps-1:0] q_s    [Steps+1];
  logic [30:0]      den_s  [Steps+1];
  logic [SideW-1:0] side_s [Steps+1];
  logic             vld_s  [Steps+1];

  // dividend is num * 2^30; its top bits seed the remainder
  assign rem_s[0]  = {10'b0, num_i[30:10]};
  assign lo_s[0]   = {num_i[9:0], 30'b0};
  assign q_s[0]    = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [31:0]      trial;
    logic             ge;
    logic [30:0]      rem_q, den_q;
    logic [Steps-1:0] lo_q, q_q;
    logic [SideW-1:0] side_q;
    logic             vld_q;

    assign trial = {rem_s[k], lo_s[k][Steps-1]};
    assign ge    = trial >= {1'b0, den_s[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= ge ? 31'(trial - {1'b0, den_s[k]}) : trial[30:0];
      lo_q   <= lo_s[k] << 1;
      q_q    <= {q_s[k][Steps-2:0], ge};
      den_q  <= den_s[k];
      side_q <= side_s[k];
    end

    assign rem_s[k+1]  = rem_q;
    assign lo_s[k+1]   = lo_q;
    assign q_s[k+1]    = q_q;
    assign den_s[k+1]  = den_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[Steps];
  assign quot_o  = q_s[Steps];
  assign side_o  = side_s[Steps];

endmodule

>>> sv/quaternion_slerp_unit.sv
// quaternion slerp unit
// a request carries two unit quaternions and a fraction t; pulse start with the
// request on req_i and it is taken at that clock edge. busy stays low, so a new
// request may be given in every cycle.
// each request gives one result on res_o, marked by valid_o for one cycle,
// once it has passed through the whole pipeline; results leave in request order
// stages in order: dot product, sign flip and radicand, the square root, the
// arccosine cordic, the angle products, the sine cordic pair, the weight
// dividers, and last blend and saturation
// throughput: one request per cycle, every unit is fully pipelined
// reset clears all valid bits; requests in flight are dropped and nothing
// appears on valid_o until new requests come through.
// the receiver cannot stall: a result is taken in the cycle it is shown
`include "quaternion_slerp_unit_defines.svh"

module quaternion_slerp_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qsl_pkg::qsl_req_t req_i,
  output logic              valid_o,
  output qsl_pkg::qsl_res_t res_o
);

  localparam int unsigned Latency = 4 + qsl_pkg::IsqrtSteps + 2 * qsl_pkg::CordicSteps
                                    + 1 + qsl_pkg::QuotBits + 2;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: products
  logic [3:0][15:0]   a_in, b_in;
  logic [15:0]        t_sat;
  logic               v1_q;
  logic [3:0][15:0]   a1_q, b1_q;
  logic [15:0]        t1_q;
  logic signed [31:0] p1_q [4];

  assign a_in  = {req_i.first_z, req_i.first_y, req_i.first_x, req_i.first_w};
  assign b_in  = {req_i.second_z, req_i.second_y, req_i.second_x, req_i.second_w};
  assign t_sat = (req_i.fraction > 16'(qsl_pkg::TOne)) ? 16'(qsl_pkg::TOne) : req_i.fraction;

  always_ff @(posedge clk_i) begin
    a1_q <= a_in;
    b1_q <= b_in;
    t1_q <= t_sat;
    for (int k = 0; k < 4; k++) begin
      p1_q[k] <= $signed(a_in[k]) * $signed(b_in[k]);
    end
  end

  // stage 2: dot product
  logic               v2_q;
  logic [3:0][15:0]   a2_q, b2_q;
  logic [15:0]        t2_q;
  logic signed [33:0] dot2_q;

  always_ff @(posedge clk_i) begin
    a2_q   <= a1_q;
    b2_q   <= b1_q;
    t2_q   <= t1_q;
    dot2_q <= 34'(p1_q[0]) + 34'(p1_q[1]) + 34'(p1_q[2]) + 34'(p1_q[3]);
  end

  // stage 3: shorter arc flip and near-equal test
  logic               neg3;
  logic [33:0]        dabs3;
  qsl_pkg::qsl_side_t side3_d, side3_q;
  logic [29:0]        c30_3_q;
  logic               v3_q;

  assign neg3  = dot2_q[33];
  assign dabs3 = neg3 ? 34'(-dot2_q) : 34'(dot2_q);

  always_comb begin
    side3_d.a      = a2_q;
    side3_d.t      = t2_q;
    side3_d.linear = dabs3 >= 34'(qsl_pkg::OneQ28 - qsl_pkg::EpsQ28);
    for (int k = 0; k < 4; k++) begin
      side3_d.b[k] = neg3 ? 17'(-$signed({b2_q[k][15], b2_q[k]}))
                          : {b2_q[k][15], b2_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    c30_3_q <= {dabs3[27:0], 2'b00};
  end

  // stage 4: radicand for sin w
  qsl_pkg::qsl_sq_t sq4_q;
  logic [60:0]      rad4_q;
  logic             v4_q;

  always_ff @(posedge clk_i) begin
    sq4_q.side <= side3_q;
    sq4_q.c30  <= c30_3_q;
    rad4_q     <= 61'(61'(1) << 60) - 61'(60'(c30_3_q) * 60'(c30_3_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // square root
  logic             sqv;
  logic [30:0]      root;
  qsl_pkg::qsl_sq_t sq_out;

  qsl_isqrt #(
    .SideW($bits(qsl_pkg::qsl_sq_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v4_q),
    .rad_i  (rad4_q),
    .side_i (sq4_q),
    .valid_o(sqv),
    .root_o (root),
    .side_o (sq_out)
  );

  // arccosine by vectoring
  qsl_pkg::qsl_vec_t  vec_in, vec_out;
  logic               vecv;
  logic signed [32:0] omega_z;

  assign vec_in.side = sq_out.side;
  assign vec_in.root = root;

  qsl_cordic #(
    .Vectoring(1'b1),
    .SideW    ($bits(qsl_pkg::qsl_vec_t))
  ) u_acos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sqv),
    .x_i    ({4'b0, sq_out.c30}),
    .y_i    ({3'b0, root}),
    .z_i    ('0),
    .side_i (vec_in),
    .valid_o(vecv),
    .y_o    (),
    .z_o    (omega_z),
    .side_o (vec_out)
  );

  // angle products
  logic [31:0]       omega;
  logic [16:0]       tc_v, tv_v;
  logic [48:0]       prod1, prod2;
  logic              va_q;
  logic [31:0]       ang1_q, ang2_q;
  qsl_pkg::qsl_vec_t vec_q;

  assign omega = omega_z[32] ? '0 : omega_z[31:0];
  assign tc_v  = 17'(qsl_pkg::TOne) - {1'b0, vec_out.side.t};
  assign tv_v  = {1'b0, vec_out.side.t};
  assign prod1 = 49'(omega) * 49'(tc_v);
  assign prod2 = 49'(omega) * 49'(tv_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= vecv;
    end
  end

  always_ff @(posedge clk_i) begin
    ang1_q <= prod1[46:15];
    ang2_q <= prod2[46:15];
    vec_q  <= vec_out;
  end

  // sine lanes
  qsl_pkg::qsl_lane_a_t lane_a_in, lane_a_out;
  qsl_pkg::qsl_lane_b_t lane_b_in, lane_b_out;
  logic                 sinv;
  logic signed [33:0]   sin1_y, sin2_y;
  logic [30:0]          sin1, sin2;

  assign lane_a_in.a      = vec_q.side.a;
  assign lane_a_in.linear = vec_q.side.linear;
  assign lane_a_in.root   = vec_q.root;
  assign lane_b_in.b      = vec_q.side.b;
  assign lane_b_in.t      = vec_q.side.t;

  qsl_cordic #(
    .Vectoring(1'b0),
    .SideW    ($bits(qsl_pkg::qsl_lane_a_t))
  ) u_sin_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(va_q),
    .x_i    (34'(qsl_pkg::CordicGain)),
    .y_i    ('0),
    .z_i    ({1'b0, ang1_q}),
    .side_i (lane_a_in),
    .valid_o(sinv),
    .y_o    (sin1_y),
    .z_o    (),
    .side_o (lane_a_out)
  );

  qsl_cordic #(
    .Vectoring(1'b0),
    .SideW    ($bits(qsl_pkg::qsl_lane_b_t))
  ) u_sin_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(va_q),
    .x_i    (34'(qsl_pkg::CordicGain)),
    .y_i    ('0),
    .z_i    ({1'b0, ang2_q}),
    .side_i (lane_b_in),
    .valid_o(),
    .y_o    (sin2_y),
    .z_o    (),
    .side_o (lane_b_out)
  );

  assign sin1 = sin1_y[33] ? '0 : sin1_y[30:0];
  assign sin2 = sin2_y[33] ? '0 : sin2_y[30:0];

  // weight dividers
  qsl_pkg::qsl_div_a_t  div_a_in, div_a_out;
  qsl_pkg::qsl_lane_b_t div_b_out;
  logic                 divv;
  logic [qsl_pkg::QuotBits-1:0] q1, q2;

  assign div_a_in.a      = lane_a_out.a;
  assign div_a_in.linear = lane_a_out.linear;

  qsl_divider #(
    .SideW($bits(qsl_pkg::qsl_div_a_t))
  ) u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sinv),
    .num_i  (sin1),
    .den_i  (lane_a_out.root),
    .side_i (div_a_in),
    .valid_o(divv),
    .quot_o (q1),
    .side_o (div_a_out)
  );

  qsl_divider #(
    .SideW($bits(qsl_pkg::qsl_lane_b_t))
  ) u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sinv),
    .num_i  (sin2),
    .den_i  (lane_a_out.root),
    .side_i (lane_b_out),
    .valid_o(),
    .quot_o (q2),
    .side_o (div_b_out)
  );

  // blend products
  logic [qsl_pkg::QuotBits-1:0] w1, w2;
  logic [16:0]                  tcb;
  logic                         vm_q;
  logic signed [57:0]           pa_q [4];
  logic signed [57:0]           pb_q [4];

  assign tcb = 17'(qsl_pkg::TOne) - {1'b0, div_b_out.t};
  assign w1  = div_a_out.linear ? (40'(tcb) << 15) : q1;
  assign w2  = div_a_out.linear ? (40'(div_b_out.t) << 15) : q2;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      pa_q[k] <= $signed({1'b0, w1}) * $signed(div_a_out.a[k]);
      pb_q[k] <= $signed({1'b0, w2}) * $signed(div_b_out.b[k]);
    end
  end

  // round and saturate
  logic [3:0][15:0]  outv;
  logic              vo_q;
  qsl_pkg::qsl_res_t res_q;

  always_comb begin
    logic signed [58:0] acc;
    logic signed [28:0] r;
    for (int k = 0; k < 4; k++) begin
      acc = {pa_q[k][57], pa_q[k]} + {pb_q[k][57], pb_q[k]} + 59'sd536870912;
      r   = acc[58:30];
      if (r > 29'sd32767) begin
        outv[k] = 16'h7fff;
      end else if (r < -29'sd32768) begin
        outv[k] = 16'h8000;
      end else begin
        outv[k] = r[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.out_w <= outv[0];
    res_q.out_x <= outv[1];
    res_q.out_y <= outv[2];
    res_q.out_z <= outv[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vm_q <= divv;
      vo_q <= vm_q;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

  `QSL_ASSERT_IMPLIES(a_req_gives_result, accept, ##Latency valid_o)
  `QSL_ASSERT_IMPLIES(a_result_had_request, valid_o, $past(accept, Latency))
  `QSL_ASSERT_IMPLIES(a_root_large, sqv && !sq_out.side.linear, root >= 31'(1 << 22))
  `QSL_ASSERT_NEXT(a_mult_feeds_out, vm_q, vo_q)

endmodule
